// ----- rtl/core/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg
// Shared constants and types for the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int MAX_K  = 15;
    localparam int DEPTH  = MAX_K + 1;
    localparam int VAL_W  = 32;
    localparam int K_W    = 4;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // per-cycle command shared by every cell of the window chain
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_INSERT     = 2'd1,
        CELL_POP_INSERT = 2'd2,
        CELL_POP        = 2'd3
    } t_cell_op;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    ahead;    // held value sorts ahead of the new value
        logic signed [VAL_W-1:0] value;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ----- rtl/core/kss_cell.sv -----
// ----------------------------------------------------------------------------
// kss_cell
// One slot of the sorted window: holds a value and shifts or inserts per op.
// ----------------------------------------------------------------------------
module kss_cell
    import kss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_op                i_op,
    input  logic                    i_head,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_link                   i_left,
    input  t_link                   i_right,
    output t_link                   o_link
);

    logic                    r_valid;
    logic                    n_valid;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    w_before;

    // equal values stay ahead of the newcomer
    assign w_before = r_valid && !(i_value < r_value);

    assign o_link.valid = r_valid;
    assign o_link.ahead = w_before;
    assign o_link.value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        unique case (i_op)
            CELL_HOLD: begin
                n_valid = r_valid;
            end
            CELL_INSERT: begin
                n_valid = r_valid | i_left.valid;
                if (w_before) begin
                    n_value = r_value;
                end else if (i_left.ahead) begin
                    n_value = i_value;
                end else begin
                    n_value = i_left.value;
                end
            end
            CELL_POP_INSERT: begin
                // head value leaves, so values that sort ahead of the new value move one place toward the head
                if (i_right.ahead) begin
                    n_value = i_right.value;
                end else if (i_head || w_before) begin
                    n_value = i_value;
                end else begin
                    n_value = r_value;
                end
            end
            CELL_POP: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/core/k_sorted_stream_sorter.sv -----
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a stream whose values sit at most k places from their sorted spot.
// ----------------------------------------------------------------------------
// release: a released minimum appears on the master side in the cycle after
//   the slave transaction that releases it
// throughput: one slave transaction per cycle while o_s_tready is high; a list
//   end then drains the window chain, one result per cycle when output is free
// reset: synchronous active-low, empties the window and sets window_k to 2
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter
    import kss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [K_W-1:0]   i_cfg_data,     // window_k
    // slave stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [VAL_W-1:0] i_s_tdata,      // value
    input  logic             i_s_tlast,      // end_of_list
    // master stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [VAL_W-1:0] o_m_tdata,      // sorted_value
    output logic             o_m_tlast       // last_out
);

    t_state           r_state;
    t_state           n_state;
    logic [K_W-1:0]   r_window_k;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [K_W-1:0]   w_k_sat;
    logic [CNT_W-1:0] w_cap;
    logic             w_need_pop;
    logic             w_out_free;
    logic             w_accept;
    logic             w_drain_step;
    t_cell_op         w_op;

    logic             r_out_valid;
    logic             n_out_valid;
    logic [VAL_W-1:0] r_out_data;
    logic [VAL_W-1:0] n_out_data;
    logic             r_out_last;
    logic             n_out_last;

    t_link            w_link [DEPTH];
    logic [DEPTH-1:0] w_valid_vec;
    t_link            w_head_link;
    t_link            w_tail_link;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_k <= K_W'(2);
        end else if (i_cfg_valid) begin
            r_window_k <= i_cfg_data;
        end
    end

    assign w_k_sat    = (r_window_k > K_W'(MAX_K)) ? K_W'(MAX_K) : r_window_k;
    assign w_cap      = CNT_W'(w_k_sat) + CNT_W'(1);
    assign w_need_pop = (r_count >= w_cap);
    assign w_out_free = !r_out_valid || i_m_tready;

    // an item that releases nothing is taken even while a result waits
    assign o_s_tready   = (r_state == ST_IDLE) && (!w_need_pop || w_out_free);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_drain_step = (r_state == ST_DRAIN) && w_out_free;

    always_comb begin
        if (w_accept) begin
            w_op = w_need_pop ? CELL_POP_INSERT : CELL_INSERT;
        end else if (w_drain_step) begin
            w_op = CELL_POP;
        end else begin
            w_op = CELL_HOLD;
        end
    end

    // window chain, cell 0 holds the minimum
    assign w_head_link.valid = 1'b1;
    assign w_head_link.ahead = 1'b1;
    assign w_head_link.value = '0;
    assign w_tail_link.valid = 1'b0;
    assign w_tail_link.ahead = 1'b0;
    assign w_tail_link.value = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_link w_left;
        t_link w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_head_link;
        end else begin : g_mid_l
            assign w_left = w_link[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_tail_link;
        end else begin : g_mid_r
            assign w_right = w_link[gi+1];
        end

        kss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_head  (gi == 0),
            .i_value ($signed(i_s_tdata)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[gi])
        );

        assign w_valid_vec[gi] = w_link[gi].valid;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!w_need_pop) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_drain_step) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (w_accept && w_need_pop) begin
            n_out_valid = 1'b1;
            n_out_data  = w_link[0].value;
            n_out_last  = 1'b0;
        end else if (w_drain_step) begin
            n_out_valid = 1'b1;
            n_out_data  = w_link[0].value;
            n_out_last  = (r_count == CNT_W'(1));
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // the number of occupied cells always matches the count
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(w_valid_vec)) == r_count)
        else $error("window occupancy does not match count");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("drain with empty window");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_drain_step && r_count == CNT_W'(1)) |=> (r_state == ST_IDLE && r_count == '0))
        else $error("drain did not finish with an empty window");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_link[0].valid && w_link[1].valid) |-> (w_link[0].value <= w_link[1].value))
        else $error("window head out of order");

    a_release_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_need_pop) |=> (r_out_valid && !r_out_last))
        else $error("release transaction not presented");

endmodule
